@@ rtl/greedy_graph_coloring_unit_macros.svh @@
// -----------------------------------------------------------------------------
// Greedy graph coloring unit: assertion macros
// Concurrent check macros shared by the RTL; empty when SYNTHESIS is defined.
// -----------------------------------------------------------------------------
`ifndef GREEDY_GRAPH_COLORING_UNIT_MACROS_SVH
`define GREEDY_GRAPH_COLORING_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define GGC_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("ggc: same-cycle check failed");
// next-cycle implication
`define GGC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("ggc: next-cycle check failed");
`else
`define GGC_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define GGC_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

@@ rtl/ggc_pkg.sv @@
// -----------------------------------------------------------------------------
// Greedy graph coloring package
// Field widths, default sizes, controller states and control/status bundles.
// -----------------------------------------------------------------------------
package ggc_pkg;

    // fixed field widths
    localparam int FIELD_W          = 10;
    localparam int COUNT_W          = 11;
    // color/vertex slot ceiling and bitmap row width
    localparam int COLOR_SLOTS_MAX  = 1024;
    localparam int ROW_BITS_MAX     = 32;
    localparam int DEF_MAX_VERTICES = 1024;

    typedef enum logic [3:0] {
        ST_INIT_CLR,
        ST_IDLE,
        ST_START_CLR,
        ST_LOOKUP,
        ST_MARK_RD,
        ST_MARK_WR,
        ST_SEARCH,
        ST_PICK,
        ST_EMIT
    } ggc_state_t;

    // controller -> datapath
    typedef struct packed {
        logic latch_item;   // input word accepted
        logic clr_step;     // one step of the table sweep
        logic tbl_rd;       // read color table at neighbor
        logic mark_rd;      // read bitmap row of neighbor color
        logic mark_wr;      // write back marked row
        logic search;       // pick first non-full row, read it
        logic pick;         // choose first free color
        logic emit;         // store color, load result
    } ggc_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic clr_last;     // sweep at last entry
        logic in_start;     // start_req on the input port
        logic item_last;    // held word ends a vertex run
        logic mark_hit;     // neighbor is colored
        logic out_free;     // result register can load
    } ggc_status_t;

endpackage

@@ rtl/ggc_ram.sv @@
// -----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// -----------------------------------------------------------------------------
module ggc_ram
    import ggc_pkg::*;
#(
    parameter int WIDTH = FIELD_W,
    parameter int DEPTH = COLOR_SLOTS_MAX,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/ggc_ctrl.sv @@
// -----------------------------------------------------------------------------
// Greedy graph coloring controller
// Sequences table sweep, neighbor lookup, bitmap mark, search and result load.
// -----------------------------------------------------------------------------
module ggc_ctrl
    import ggc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  ggc_status_t status,
    output ggc_cmd_t    cmd
);

    ggc_state_t state_reg;
    ggc_state_t state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT_CLR;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT_CLR: begin
                if (status.clr_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = status.in_start ? ST_START_CLR : ST_LOOKUP;
                end
            end
            ST_START_CLR: begin
                if (status.clr_last) state_next = ST_LOOKUP;
            end
            ST_LOOKUP: state_next = ST_MARK_RD;
            ST_MARK_RD: begin
                if (status.mark_hit)       state_next = ST_MARK_WR;
                else if (status.item_last) state_next = ST_SEARCH;
                else                       state_next = ST_IDLE;
            end
            ST_MARK_WR: state_next = status.item_last ? ST_SEARCH : ST_IDLE;
            ST_SEARCH:  state_next = ST_PICK;
            ST_PICK:    state_next = ST_EMIT;
            ST_EMIT: begin
                if (status.out_free) state_next = ST_IDLE;
            end
            default:    state_next = ST_INIT_CLR;
        endcase
    end

    // outputs
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_INIT_CLR, ST_START_CLR: cmd.clr_step = 1'b1;
            ST_IDLE: begin
                s_ready        = 1'b1;
                cmd.latch_item = s_valid;
            end
            ST_LOOKUP:  cmd.tbl_rd  = 1'b1;
            ST_MARK_RD: cmd.mark_rd = status.mark_hit;
            ST_MARK_WR: cmd.mark_wr = 1'b1;
            ST_SEARCH:  cmd.search  = 1'b1;
            ST_PICK:    cmd.pick    = 1'b1;
            ST_EMIT:    cmd.emit    = status.out_free;
            default:    cmd         = '0;
        endcase
    end

endmodule

@@ rtl/ggc_datapath.sv @@
// -----------------------------------------------------------------------------
// Greedy graph coloring datapath
// Color table RAM, used-color bitmap RAM with row valid/full flags,
// first-free search, highest color tracking and the result register.
// -----------------------------------------------------------------------------
`include "greedy_graph_coloring_unit_macros.svh"

module ggc_datapath
    import ggc_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  ggc_cmd_t           cmd,
    output ggc_status_t        status,
    input  logic               s_start_req,
    input  logic [FIELD_W-1:0] s_vertex,
    input  logic [FIELD_W-1:0] s_neighbor,
    input  logic               s_has_neighbor,
    input  logic               s_last_neighbor,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [FIELD_W-1:0] m_colored_vertex,
    output logic [FIELD_W-1:0] m_color,
    output logic [COUNT_W-1:0] m_colors_used
);

    localparam int SLOTS     = (MAX_VERTICES < COLOR_SLOTS_MAX) ? MAX_VERTICES
                                                                : COLOR_SLOTS_MAX;
    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int TBL_W     = SLOT_W + 1;
    localparam int ROW_W     = (SLOTS >= ROW_BITS_MAX) ? ROW_BITS_MAX
                                                       : (1 << $clog2(SLOTS));
    localparam int BIT_W     = $clog2(ROW_W);
    localparam int ROWS      = (SLOTS + ROW_W - 1) / ROW_W;
    localparam int ROW_IDX_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam logic [COUNT_W-1:0] SLOTS_C = COUNT_W'(SLOTS);

    // held input word
    logic [FIELD_W-1:0] vertex_reg;
    logic [FIELD_W-1:0] nbr_reg;
    logic               has_nbr_reg;
    logic               last_reg;

    // sweep counter and coloring state
    logic [SLOT_W-1:0]  clr_cnt_reg;
    logic               clr_last;
    logic [SLOT_W-1:0]  highest_reg;
    logic [SLOT_W-1:0]  highest_next;
    logic [ROWS-1:0]    row_valid_reg;
    logic [ROWS-1:0]    row_full_reg;

    // lookup and mark
    logic [TBL_W-1:0]     tbl_rdata;
    logic                 tbl_wr_en;
    logic [SLOT_W-1:0]    tbl_wr_addr;
    logic [TBL_W-1:0]     tbl_wr_data;
    logic [SLOT_W-1:0]    nc;
    logic [COUNT_W-1:0]   nc_ext;
    logic [COUNT_W-1:0]   nc_row_full;
    logic                 nbr_in_range;
    logic                 vtx_in_range;
    logic                 mark_hit;
    logic [ROW_IDX_W-1:0] mark_row_reg;
    logic [BIT_W-1:0]     mark_bit_reg;
    logic [ROW_W-1:0]     bmp_rdata;
    logic [ROW_W-1:0]     mark_row_cur;
    logic [ROW_W-1:0]     mark_row_new;
    logic [ROW_IDX_W-1:0] bmp_rd_addr;

    // search and pick
    logic                 free_found;
    logic [ROW_IDX_W-1:0] free_row;
    logic                 search_ok_reg;
    logic [ROW_IDX_W-1:0] search_row_reg;
    logic [ROW_W-1:0]     pick_row;
    logic [BIT_W-1:0]     zero_bit;
    logic [COUNT_W-1:0]   cand;
    logic [SLOT_W-1:0]    color_next;
    logic [SLOT_W-1:0]    color_reg;

    // result register
    logic               m_valid_reg;
    logic [FIELD_W-1:0] m_colored_vertex_reg;
    logic [FIELD_W-1:0] m_color_reg;
    logic [COUNT_W-1:0] m_colors_used_reg;

    // capture accepted word
    always_ff @(posedge aclk) begin
        if (cmd.latch_item) begin
            vertex_reg  <= s_vertex;
            nbr_reg     <= s_neighbor;
            has_nbr_reg <= s_has_neighbor;
            last_reg    <= s_last_neighbor;
        end
    end

    // table sweep counter
    assign clr_last = (clr_cnt_reg == SLOT_W'(SLOTS - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (cmd.clr_step) begin
            clr_cnt_reg <= clr_last ? '0 : clr_cnt_reg + SLOT_W'(1);
        end
    end

    // color table: {valid, color}
    assign vtx_in_range = ({1'b0, vertex_reg} < SLOTS_C);
    assign tbl_wr_en    = cmd.clr_step | (cmd.emit & vtx_in_range);
    assign tbl_wr_addr  = cmd.clr_step ? clr_cnt_reg : vertex_reg[SLOT_W-1:0];
    assign tbl_wr_data  = cmd.clr_step ? '0 : {1'b1, color_reg};

    ggc_ram #(
        .WIDTH (TBL_W),
        .DEPTH (SLOTS)
    ) u_color_table (
        .aclk    (aclk),
        .wr_en   (tbl_wr_en),
        .wr_addr (tbl_wr_addr),
        .wr_data (tbl_wr_data),
        .rd_en   (cmd.tbl_rd),
        .rd_addr (nbr_reg[SLOT_W-1:0]),
        .rd_data (tbl_rdata)
    );

    // neighbor color and its bitmap position
    assign nc           = tbl_rdata[SLOT_W-1:0];
    assign nc_ext       = COUNT_W'(nc);
    assign nc_row_full  = nc_ext >> BIT_W;
    assign nbr_in_range = ({1'b0, nbr_reg} < SLOTS_C);
    assign mark_hit     = has_nbr_reg & nbr_in_range & tbl_rdata[SLOT_W]
                        & (nc_ext < SLOTS_C);

    always_ff @(posedge aclk) begin
        if (cmd.mark_rd) begin
            mark_row_reg <= nc_row_full[ROW_IDX_W-1:0];
            mark_bit_reg <= nc_ext[BIT_W-1:0];
        end
    end

    // first row that is not full
    always_comb begin
        free_found = 1'b0;
        free_row   = '0;
        for (int r = ROWS - 1; r >= 0; r--) begin
            if (!row_full_reg[r]) begin
                free_found = 1'b1;
                free_row   = ROW_IDX_W'(r);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.search) begin
            search_ok_reg  <= free_found;
            search_row_reg <= free_row;
        end
    end

    // used-color bitmap, one row per word
    assign bmp_rd_addr  = cmd.mark_rd ? nc_row_full[ROW_IDX_W-1:0] : free_row;
    assign mark_row_cur = row_valid_reg[mark_row_reg] ? bmp_rdata : '0;
    assign mark_row_new = mark_row_cur | (ROW_W'(1) << mark_bit_reg);

    ggc_ram #(
        .WIDTH (ROW_W),
        .DEPTH (ROWS)
    ) u_used_bitmap (
        .aclk    (aclk),
        .wr_en   (cmd.mark_wr),
        .wr_addr (mark_row_reg),
        .wr_data (mark_row_new),
        .rd_en   (cmd.mark_rd | cmd.search),
        .rd_addr (bmp_rd_addr),
        .rd_data (bmp_rdata)
    );

    // row flags: invalid rows read as empty
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clr_step || cmd.emit) begin
            row_valid_reg <= '0;
            row_full_reg  <= '0;
        end else if (cmd.mark_wr) begin
            row_valid_reg[mark_row_reg] <= 1'b1;
            row_full_reg[mark_row_reg]  <= &mark_row_new;
        end
    end

    // first free bit in the chosen row, saturate at the top slot
    assign pick_row = row_valid_reg[search_row_reg] ? bmp_rdata : '0;

    always_comb begin
        zero_bit = '0;
        for (int b = ROW_W - 1; b >= 0; b--) begin
            if (!pick_row[b]) zero_bit = BIT_W'(b);
        end
    end

    assign cand       = (COUNT_W'(search_row_reg) << BIT_W) | COUNT_W'(zero_bit);
    assign color_next = (search_ok_reg && (cand < SLOTS_C)) ? cand[SLOT_W-1:0]
                                                           : SLOT_W'(SLOTS - 1);

    always_ff @(posedge aclk) begin
        if (cmd.pick) begin
            color_reg <= color_next;
        end
    end

    // highest color since the last start
    assign highest_next = (color_reg > highest_reg) ? color_reg : highest_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clr_step) begin
            highest_reg <= '0;
        end else if (cmd.emit) begin
            highest_reg <= highest_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_colored_vertex_reg <= vertex_reg;
            m_color_reg          <= FIELD_W'(color_reg);
            m_colors_used_reg    <= COUNT_W'(highest_next) + COUNT_W'(1);
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_colored_vertex = m_colored_vertex_reg;
    assign m_color          = m_color_reg;
    assign m_colors_used    = m_colors_used_reg;

    // status to controller
    assign status.clr_last  = clr_last;
    assign status.in_start  = s_start_req;
    assign status.item_last = last_reg;
    assign status.mark_hit  = mark_hit;
    assign status.out_free  = ~m_valid_reg | m_ready;

    // checks
    `GGC_ASSERT_IMPL(a_emit_slot_free, aclk, aresetn, cmd.emit, (!m_valid_reg || m_ready))
    `GGC_ASSERT_NEXT(a_mark_rmw, aclk, aresetn, cmd.mark_rd, cmd.mark_wr)
    `GGC_ASSERT_IMPL(a_color_below_count, aclk, aresetn, m_valid_reg, (COUNT_W'(m_color_reg) < m_colors_used_reg))

endmodule

@@ rtl/greedy_graph_coloring_unit.sv @@
// A neighbor word passes accept, table read, bitmap read and bitmap write; the write is
//   skipped when the neighbor is uncolored. A last word adds search, pick and load, and
//   the load waits while the result register is full. One word is in work at a time.
// start_req first sweeps all min(MAX_VERTICES,1024) table entries, then handles the word.
// Reset: synchronous, active low; afterwards the same sweep runs (s_ready low) to clear marks.
// -----------------------------------------------------------------------------
// Greedy graph coloring unit
// First-fit vertex coloring: marks neighbor colors, assigns least free color.
// -----------------------------------------------------------------------------
module greedy_graph_coloring_unit
    import ggc_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_start_req,
    input  logic [FIELD_W-1:0] s_vertex,
    input  logic [FIELD_W-1:0] s_neighbor,
    input  logic               s_has_neighbor,
    input  logic               s_last_neighbor,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [FIELD_W-1:0] m_colored_vertex,
    output logic [FIELD_W-1:0] m_color,
    output logic [COUNT_W-1:0] m_colors_used
);

    ggc_cmd_t    cmd;
    ggc_status_t status;

    // sequencer
    ggc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // tables, bitmap and result register
    ggc_datapath #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .status           (status),
        .s_start_req      (s_start_req),
        .s_vertex         (s_vertex),
        .s_neighbor       (s_neighbor),
        .s_has_neighbor   (s_has_neighbor),
        .s_last_neighbor  (s_last_neighbor),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_colored_vertex (m_colored_vertex),
        .m_color          (m_color),
        .m_colors_used    (m_colors_used)
    );

endmodule

@@ verif/greedy_graph_coloring_unit_tb.sv @@
// -----------------------------------------------------------------------------
// Greedy graph coloring unit testbench
// Streams vertex runs (one word per neighbor, last word picks the color) into
// the unit. A local first-fit model keeps its own color table, colored marks
// and used-color bitmap, and queues one expected coloring per last word. Every
// result taken from the unit is compared field by field against that queue.
// Traffic mixes bursty and steady sending with random and patterned stalls on
// the result side, including one long hold-off that backs the unit up.
// -----------------------------------------------------------------------------
module greedy_graph_coloring_unit_tb;
    import ggc_pkg::*;

    localparam int SLOTS       = COLOR_SLOTS_MAX;
    localparam int ITEM_TARGET = 750;
    localparam int CYCLE_LIMIT = 400000;
    localparam int END_WAIT    = 16;
    localparam int HOLD_CYCLES = 400;

    typedef logic [FIELD_W-1:0] idx_q_t[$];

    typedef struct packed {
        logic [FIELD_W-1:0] vertex;
        logic [FIELD_W-1:0] color;
        logic [COUNT_W-1:0] colors_used;
    } coloring_t;

    typedef enum int {RX_OPEN, RX_RANDOM, RX_PATTERN} rx_mode_t;

    // DUT ports
    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic               s_start_req;
    logic [FIELD_W-1:0] s_vertex;
    logic [FIELD_W-1:0] s_neighbor;
    logic               s_has_neighbor;
    logic               s_last_neighbor;
    logic               m_valid;
    logic               m_ready;
    logic [FIELD_W-1:0] m_colored_vertex;
    logic [FIELD_W-1:0] m_color;
    logic [COUNT_W-1:0] m_colors_used;

    // local coloring state
    logic [FIELD_W-1:0] color_of [0:SLOTS-1];
    bit                 is_colored [0:SLOTS-1];
    bit                 color_taken [0:SLOTS-1];
    logic [FIELD_W-1:0] top_color;
    coloring_t          pending_colorings[$];

    // traffic control
    int       items_sent   = 0;
    int       mismatch_cnt = 0;
    int       cycle_cnt    = 0;
    bit       tx_bursty    = 0;
    int       burst_left   = 1;
    rx_mode_t rx_mode      = RX_OPEN;
    logic [15:0] rx_mask   = 16'hffff;
    bit       hold_req     = 0;
    int       hold_len     = 0;

    greedy_graph_coloring_unit uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_start_req     (s_start_req),
        .s_vertex        (s_vertex),
        .s_neighbor      (s_neighbor),
        .s_has_neighbor  (s_has_neighbor),
        .s_last_neighbor (s_last_neighbor),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_colored_vertex(m_colored_vertex),
        .m_color         (m_color),
        .m_colors_used   (m_colors_used)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // first-fit model: marks neighbor colors, picks least free color on last word
    function automatic void predict_coloring(input logic st, input logic [FIELD_W-1:0] v,
                                             input logic [FIELD_W-1:0] n, input logic hn,
                                             input logic ln);
        int        c;
        int        pick;
        coloring_t res;
        if (st) begin
            for (c = 0; c < SLOTS; c++) begin
                is_colored[c]  = 0;
                color_taken[c] = 0;
            end
            top_color = '0;
        end
        if (hn && is_colored[n])
            color_taken[color_of[n]] = 1;
        if (!ln)
            return;
        // saturate to the top slot when every color is taken
        pick = SLOTS - 1;
        for (c = SLOTS - 1; c >= 0; c--) begin
            if (!color_taken[c])
                pick = c;
        end
        color_of[v]   = pick[FIELD_W-1:0];
        is_colored[v] = 1;
        if (pick[FIELD_W-1:0] > top_color)
            top_color = pick[FIELD_W-1:0];
        for (c = 0; c < SLOTS; c++)
            color_taken[c] = 0;
        res.vertex      = v;
        res.color       = pick[FIELD_W-1:0];
        res.colors_used = {1'b0, top_color} + 1'b1;
        pending_colorings.push_back(res);
    endfunction

    function automatic void flag_mismatch(input string field, input int unsigned want_v,
                                          input int unsigned got_v);
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
            $display("mismatch on %s: expected %0d, got %0d", field, want_v, got_v);
    endfunction

    // result check on every accepted word
    always @(posedge aclk) begin : result_check
        coloring_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_colorings.size() == 0) begin
                flag_mismatch("unexpected result, vertex", 0, 32'(m_colored_vertex));
            end else begin
                want = pending_colorings.pop_front();
                if (m_colored_vertex !== want.vertex)
                    flag_mismatch("colored_vertex", 32'(want.vertex), 32'(m_colored_vertex));
                if (m_color !== want.color)
                    flag_mismatch("color", 32'(want.color), 32'(m_color));
                if (m_colors_used !== want.colors_used)
                    flag_mismatch("colors_used", 32'(want.colors_used), 32'(m_colors_used));
            end
        end
    end

    // receiver: open, random or masked stalls, plus an occasional long hold
    initial begin : receiver
        int hold_left;
        int phase;
        hold_left = 0;
        phase     = 0;
        m_ready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_left = hold_len;
                hold_req  = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                case (rx_mode)
                    RX_OPEN:    m_ready <= 1'b1;
                    RX_RANDOM:  m_ready <= ($urandom_range(0, 99) < 55);
                    default:    m_ready <= rx_mask[phase % 16];
                endcase
            end
            phase++;
        end
    end

    // send one word and wait for it to be taken; bursts end in a random gap
    task automatic send_word(input logic st, input logic [FIELD_W-1:0] v,
                             input logic [FIELD_W-1:0] n, input logic hn, input logic ln);
        @(negedge aclk);
        s_valid         <= 1'b1;
        s_start_req     <= st;
        s_vertex        <= v;
        s_neighbor      <= n;
        s_has_neighbor  <= hn;
        s_last_neighbor <= ln;
        forever begin
            @(posedge aclk);
            if (s_ready)
                break;
        end
        predict_coloring(st, v, n, hn, ln);
        items_sent++;
        if (tx_bursty) begin
            burst_left--;
            if (burst_left <= 0) begin
                @(negedge aclk);
                s_valid <= 1'b0;
                repeat ($urandom_range(0, 6)) @(negedge aclk);
                burst_left = $urandom_range(1, 10);
            end
        end
    endtask

    // pause the sender until every expected coloring has arrived
    task automatic wait_for_colorings();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_colorings.size() != 0)
            @(posedge aclk);
    endtask

    // one vertex: a word per neighbor, last word closes the run;
    // a noisy run scrambles the vertex field on inner words and adds an empty word
    task automatic send_vertex_run(input bit is_first, input logic [FIELD_W-1:0] v,
                                   input idx_q_t nbrs, input bit noisy);
        int i;
        bit is_last;
        logic [FIELD_W-1:0] vf;
        if (nbrs.size() == 0) begin
            send_word(is_first, v, FIELD_W'($urandom_range(0, SLOTS - 1)), 1'b0, 1'b1);
        end else begin
            for (i = 0; i < nbrs.size(); i++) begin
                is_last = (i == nbrs.size() - 1);
                vf = (noisy && !is_last) ? FIELD_W'($urandom_range(0, SLOTS - 1)) : v;
                send_word(is_first && i == 0, vf, nbrs[i], 1'b1, is_last);
                if (noisy && i == 0 && !is_last)
                    send_word(1'b0, v, FIELD_W'($urandom_range(0, SLOTS - 1)), 1'b0, 1'b0);
            end
        end
    endtask

    // extremes of the fields and the corner cases, one by one
    task automatic test_directed_cases();
        tx_bursty = 0;
        rx_mode   = RX_OPEN;
        // start on a lone vertex, then extreme indexes
        send_word(1'b1, 10'd0,    10'd0,    1'b0, 1'b1);
        send_word(1'b0, 10'd1023, 10'd0,    1'b1, 1'b1);
        send_word(1'b0, 10'd5,    10'd0,    1'b1, 1'b0);
        send_word(1'b0, 10'd5,    10'd1023, 1'b1, 1'b1);
        // empty neighbor word pointing at a colored vertex marks nothing
        send_word(1'b0, 10'd7,    10'd1023, 1'b0, 1'b1);
        // vertex field changes within a run; last word's vertex is colored
        send_word(1'b0, 10'd10,   10'd0,    1'b1, 1'b0);
        send_word(1'b0, 10'd12,   10'd5,    1'b1, 1'b0);
        send_word(1'b0, 10'd11,   10'd1023, 1'b1, 1'b1);
        // uncolored neighbor, then recolor a vertex that lists itself
        send_word(1'b0, 10'd0,    10'd500,  1'b1, 1'b0);
        send_word(1'b0, 10'd0,    10'd0,    1'b1, 1'b1);
        send_word(1'b0, 10'd1023, 10'd1023, 1'b1, 1'b0);
        send_word(1'b0, 10'd1023, 10'd11,   1'b1, 1'b1);
        // start lands on an inner neighbor word of a run
        send_word(1'b0, 10'd300,  10'd11,   1'b1, 1'b0);
        send_word(1'b1, 10'd300,  10'd1023, 1'b1, 1'b0);
        send_word(1'b0, 10'd300,  10'd5,    1'b1, 1'b1);
        send_word(1'b0, 10'd682,  10'd300,  1'b1, 1'b1);
        send_word(1'b0, 10'd341,  10'd682,  1'b1, 1'b0);
        send_word(1'b0, 10'd341,  10'd300,  1'b1, 1'b1);
        // start lands on a last word that names a previously colored vertex
        send_word(1'b1, 10'd511,  10'd341,  1'b1, 1'b1);
        send_word(1'b0, 10'd512,  10'd511,  1'b1, 1'b1);
        wait_for_colorings();
    endtask

    // complete graph: vertex k sees all earlier ones and gets color k
    task automatic test_clique();
        int k;
        idx_q_t order;
        logic [FIELD_W-1:0] v;
        tx_bursty  = 1;
        burst_left = 3;
        rx_mode    = RX_RANDOM;
        order.delete();
        for (k = 0; k < 16; k++) begin
            v = 10'(1023 - 37 * k);
            send_vertex_run(k == 0, v, order, 1'b0);
            order.push_front(v);
        end
        wait_for_colorings();
    endtask

    // long receiver hold while the sender keeps offering words back to back
    task automatic test_backpressure();
        int k;
        idx_q_t nbrs;
        idx_q_t done_vtx;
        logic [FIELD_W-1:0] v;
        tx_bursty = 0;
        rx_mode   = RX_OPEN;
        hold_len  = HOLD_CYCLES;
        hold_req  = 1;
        done_vtx.delete();
        for (k = 0; k < 14; k++) begin
            v = FIELD_W'($urandom_range(0, SLOTS - 1));
            nbrs.delete();
            repeat ($urandom_range(0, 3)) begin
                if (done_vtx.size() > 0)
                    nbrs.push_back(done_vtx[$urandom_range(0, done_vtx.size() - 1)]);
            end
            send_vertex_run(k == 0, v, nbrs, 1'b0);
            done_vtx.push_back(v);
        end
        wait_for_colorings();
    endtask

    // random graphs: each session starts a new coloring, most neighbors are
    // vertices already colored in it; some recoloring, noisy and broken runs
    task automatic test_random_graphs();
        int k;
        int n_vtx;
        bit recolor;
        idx_q_t nbrs;
        idx_q_t done_vtx;
        logic [FIELD_W-1:0] v;
        while (items_sent < ITEM_TARGET) begin
            tx_bursty  = ($urandom_range(0, 3) != 0);
            burst_left = $urandom_range(1, 10);
            rx_mode    = rx_mode_t'($urandom_range(0, 2));
            rx_mask    = 16'($urandom) | 16'h0001;
            n_vtx      = $urandom_range(3, 24);
            done_vtx.delete();
            for (k = 0; k < n_vtx; k++) begin
                recolor = (done_vtx.size() > 0) && ($urandom_range(0, 9) == 0);
                if (recolor)
                    v = done_vtx[$urandom_range(0, done_vtx.size() - 1)];
                else
                    v = FIELD_W'($urandom_range(0, SLOTS - 1));
                nbrs.delete();
                repeat ($urandom_range(0, 6)) begin
                    if (done_vtx.size() > 0 && $urandom_range(0, 3) != 0)
                        nbrs.push_back(done_vtx[$urandom_range(0, done_vtx.size() - 1)]);
                    else
                        nbrs.push_back(FIELD_W'($urandom_range(0, SLOTS - 1)));
                end
                if (recolor && $urandom_range(0, 1) == 1)
                    nbrs.push_back(v);
                send_vertex_run(k == 0, v, nbrs, $urandom_range(0, 9) == 0);
                done_vtx.push_back(v);
            end
            // broken run: marks left behind for the next start to clear
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 3))
                    send_word(1'b0, FIELD_W'($urandom_range(0, SLOTS - 1)),
                              done_vtx[$urandom_range(0, done_vtx.size() - 1)], 1'b1, 1'b0);
            end
            if ($urandom_range(0, 4) == 0)
                wait_for_colorings();
        end
    endtask

    // stimulus sequence
    initial begin
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_start_req     = 1'b0;
        s_vertex        = '0;
        s_neighbor      = '0;
        s_has_neighbor  = 1'b0;
        s_last_neighbor = 1'b0;
        top_color       = '0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed_cases();
        test_clique();
        test_backpressure();
        test_random_graphs();

        wait_for_colorings();
        repeat (END_WAIT) @(posedge aclk);
        if (mismatch_cnt == 0 && pending_colorings.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
